[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for fenwick_point_add_range_sum.
// Both macros clock on i_clk and stay quiet while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[src/fprs_pkg.sv]
// ----------------------------------------------------------------------------
// fprs_pkg
// Shared constants, state encoding and memory control type for the
// point-add / range-sum binary indexed tree.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fprs_pkg;

    // Default number of tree positions
    localparam int unsigned MAX_POSITIONS_DEF = 1024;

    // Fixed field widths
    localparam int unsigned POS_W = 11;
    localparam int unsigned AMT_W = 32;
    localparam int unsigned SUM_W = 64;
    localparam int unsigned CFG_W = 11;

    // Size register value after reset
    localparam logic [CFG_W-1:0] SIZE_RST = CFG_W'(1024);

    // Item kinds
    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD_RD,
        S_ADD_WR,
        S_QUERY,
        S_Q_FLUSH
    } t_state;

    // Memory strobes from the sequencer to the store
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

`default_nettype wire

[src/fenwick_point_add_range_sum.sv]
// ----------------------------------------------------------------------------
// fenwick_point_add_range_sum
// Binary indexed tree of 64-bit partial sums: point add and range sum query.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item is taken at a clock edge with i_start high and
//   o_busy low. i_kind selects add (amount at position) or range query
//   (sum of positions i_position..i_upper).
//   Result channel: a query gives one beat, o_valid high for one cycle with
//   o_range_sum; an add gives no beat. The receiver cannot stall the block.
//   Config: i_cfg_wr_en writes i_cfg_wr_data into the size register, which
//   bounds the upward walk of an add. Write it only while o_busy is low.
// Sequencing:
//   An add walks up to eleven tree nodes for 1024 positions, from position
//   1 upward: each node is a memory read then a read-modify-write through
//   the one 64-bit adder.
//   A query walks the upper prefix, then the low prefix, subtracted. Reads
//   are issued back to back; the shared adder adds each in the cycle after.
//   The result beat shows in the first cycle that o_busy is low again.
// Reset:
//   Synchronous, active low. The size register returns to 1024 and a
//   clearing pass zeroes every store entry, one entry a cycle, with o_busy
//   high throughout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module fenwick_point_add_range_sum #(
    parameter int unsigned MAX_POSITIONS = fprs_pkg::MAX_POSITIONS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // command channel
    input  wire logic                              i_start,
    output logic                                   o_busy,
    input  wire logic                              i_kind,
    input  wire logic [fprs_pkg::POS_W-1:0]        i_position,
    input  wire logic [fprs_pkg::POS_W-1:0]        i_upper,
    input  wire logic signed [fprs_pkg::AMT_W-1:0] i_amount,
    // result channel
    output logic                                   o_valid,
    output logic signed [fprs_pkg::SUM_W-1:0]      o_range_sum,
    // configuration
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [fprs_pkg::CFG_W-1:0]        i_cfg_wr_data
);
    import fprs_pkg::*;

    localparam int unsigned AW = $clog2(MAX_POSITIONS);
    // index holds any position and the overshoot of an upward walk
    localparam int unsigned IW = ((AW + 2) > POS_W) ? (AW + 2) : POS_W;
    localparam logic [IW-1:0] MAX_IDX  = IW'(MAX_POSITIONS);
    localparam logic [AW-1:0] LAST_ADR = AW'(MAX_POSITIONS - 1);

    t_state r_state, n_state;

    logic [IW-1:0]    r_idx, n_idx;
    logic [IW-1:0]    r_lo, n_lo;
    logic             r_phase, n_phase;
    logic             r_pend, n_pend;
    logic             r_pend_sub, n_pend_sub;
    logic [SUM_W-1:0] r_acc, n_acc;
    logic [AMT_W-1:0] r_delta, n_delta;
    logic [CFG_W-1:0] r_size;
    logic [AW-1:0]    r_clr_addr, n_clr_addr;
    logic             r_valid, n_valid;
    logic [SUM_W-1:0] r_sum, n_sum;

    t_mem_ctl         w_ctl;
    logic [AW-1:0]    w_wr_addr;
    logic [SUM_W-1:0] w_wr_data;
    logic [SUM_W-1:0] w_rd_data;

    logic [IW-1:0]    w_size_ext;
    logic [IW-1:0]    w_limit;
    logic [IW-1:0]    w_low;
    logic [IW-1:0]    w_idx_m1;
    logic [IW-1:0]    w_upper_ext;
    logic [IW-1:0]    w_pos_ext;
    logic [IW-1:0]    w_pos_m1;
    logic [IW-1:0]    w_hi_start;
    logic [IW-1:0]    w_lo_start;
    logic             w_accept;

    logic [SUM_W-1:0] w_op_a;
    logic [SUM_W-1:0] w_op_b;
    logic             w_sub;
    logic [SUM_W-1:0] w_sum;

    // Effective size, lowest set bit, memory address of the current node
    assign w_size_ext = IW'(r_size);
    assign w_limit    = (w_size_ext > MAX_IDX) ? MAX_IDX : w_size_ext;
    assign w_low      = r_idx & (~r_idx + IW'(1));
    assign w_idx_m1   = r_idx - IW'(1);

    // Saturate query prefix indexes to the store depth
    assign w_upper_ext = IW'(i_upper);
    assign w_pos_ext   = IW'(i_position);
    assign w_pos_m1    = w_pos_ext - IW'(1);
    assign w_hi_start  = (w_upper_ext > MAX_IDX) ? MAX_IDX : w_upper_ext;
    assign w_lo_start  = (w_pos_ext == '0) ? '0 :
                         ((w_pos_m1 > MAX_IDX) ? MAX_IDX : w_pos_m1);

    assign w_accept = i_start && (r_state == S_IDLE);
    assign o_busy   = (r_state != S_IDLE);

    // Shared 64-bit adder: node update during an add, accumulate during a query
    always_comb begin
        if (r_state == S_ADD_WR) begin
            w_op_a = w_rd_data;
            w_op_b = {{(SUM_W - AMT_W){r_delta[AMT_W-1]}}, r_delta};
            w_sub  = 1'b0;
        end else begin
            w_op_a = r_acc;
            w_op_b = w_rd_data;
            w_sub  = r_pend_sub;
        end
    end
    assign w_sum = w_op_a + (w_sub ? ~w_op_b : w_op_b) + SUM_W'(w_sub);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == LAST_ADR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_state = (i_kind == KIND_ADD) ? S_ADD_RD : S_QUERY;
                end
            end
            S_ADD_RD: begin
                if ((r_idx == '0) || (r_idx > w_limit)) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_ADD_WR;
                end
            end
            S_ADD_WR: begin
                n_state = S_ADD_RD;
            end
            S_QUERY: begin
                if ((r_idx == '0) && r_phase) begin
                    n_state = S_Q_FLUSH;
                end
            end
            S_Q_FLUSH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath and memory control
    always_comb begin
        n_idx      = r_idx;
        n_lo       = r_lo;
        n_phase    = r_phase;
        n_pend     = 1'b0;
        n_pend_sub = r_pend_sub;
        n_acc      = r_acc;
        n_delta    = r_delta;
        n_clr_addr = r_clr_addr;
        n_valid    = 1'b0;
        n_sum      = r_sum;
        w_ctl      = '0;
        w_wr_addr  = w_idx_m1[AW-1:0];
        w_wr_data  = w_sum;

        // fold in the node read last cycle
        if (r_pend) begin
            n_acc = w_sum;
        end

        unique case (r_state)
            S_CLEAR: begin
                w_ctl.wr_en = 1'b1;
                w_wr_addr   = r_clr_addr;
                w_wr_data   = '0;
                n_clr_addr  = r_clr_addr + AW'(1);
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_acc   = '0;
                    n_phase = 1'b0;
                    n_delta = i_amount;
                    n_lo    = w_lo_start;
                    n_idx   = (i_kind == KIND_ADD) ? w_pos_ext : w_hi_start;
                end
            end
            S_ADD_RD: begin
                if ((r_idx != '0) && (r_idx <= w_limit)) begin
                    w_ctl.rd_en = 1'b1;
                end
            end
            S_ADD_WR: begin
                w_ctl.wr_en = 1'b1;
                n_idx       = r_idx + w_low;
            end
            S_QUERY: begin
                if (r_idx != '0) begin
                    w_ctl.rd_en = 1'b1;
                    n_idx       = r_idx - w_low;
                    n_pend      = 1'b1;
                    n_pend_sub  = r_phase;
                end else if (!r_phase) begin
                    // switch to the low prefix, subtracted
                    n_phase = 1'b1;
                    n_idx   = r_lo;
                end
            end
            S_Q_FLUSH: begin
                n_valid = 1'b1;
                n_sum   = r_acc;
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_pend     <= 1'b0;
            r_valid    <= 1'b0;
            r_size     <= SIZE_RST;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_pend     <= n_pend;
            r_valid    <= n_valid;
            if (i_cfg_wr_en) begin
                r_size <= i_cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_lo       <= n_lo;
        r_phase    <= n_phase;
        r_pend_sub <= n_pend_sub;
        r_acc      <= n_acc;
        r_delta    <= n_delta;
        r_sum      <= n_sum;
    end

    assign o_valid     = r_valid;
    assign o_range_sum = r_sum;

    fprs_store #(
        .DEPTH     (MAX_POSITIONS)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_idx_m1[AW-1:0]),
        .o_rd_data (w_rd_data)
    );

    // Checks
    `ASSERT_NEXT(a_accept_busy, w_accept, o_busy, "accepted beat did not raise busy")
    `ASSERT_IMPL(a_beat_src, o_valid, $past(r_state) == S_Q_FLUSH, "result beat outside flush")
    `ASSERT_IMPL(a_add_bound, r_state == S_ADD_WR, (r_idx != '0) && (r_idx <= w_limit), "add write out of range")
    `ASSERT_IMPL(a_no_pend_add, (r_state == S_ADD_RD) || (r_state == S_ADD_WR), !r_pend, "query read pending during add")

endmodule

`default_nettype wire

[src/fprs_store.sv]
// ----------------------------------------------------------------------------
// fprs_store
// Partial-sum memory: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fprs_store #(
    parameter int unsigned DEPTH = fprs_pkg::MAX_POSITIONS_DEF,
    localparam int unsigned AW = $clog2(DEPTH)
) (
    input  wire logic                       i_clk,
    input  wire fprs_pkg::t_mem_ctl         i_ctl,
    input  wire logic [AW-1:0]              i_wr_addr,
    input  wire logic [fprs_pkg::SUM_W-1:0] i_wr_data,
    input  wire logic [AW-1:0]              i_rd_addr,
    output logic [fprs_pkg::SUM_W-1:0]      o_rd_data
);
    import fprs_pkg::*;

    logic [SUM_W-1:0] r_mem [DEPTH];

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Register read data
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire
